// File: rtl/mtg_pkg.sv
// Package: constants, sequencer state type and tempering function for the MT19937 generator.
package mtg_pkg;

    localparam int unsigned STATE_WORDS  = 624;
    localparam int unsigned TWIST_OFFSET = 397;
    localparam int unsigned IDX_W        = $clog2(STATE_WORDS);
    localparam int unsigned WORD_W       = 32;

    localparam logic [IDX_W-1:0] LAST_IDX    = IDX_W'(STATE_WORDS - 1);
    localparam logic [IDX_W:0]   FAR_OFFSET  = (IDX_W + 1)'(TWIST_OFFSET);
    localparam logic [IDX_W:0]   WRAP_WORDS  = (IDX_W + 1)'(STATE_WORDS);

    localparam logic [WORD_W-1:0] SEED_MULT    = 32'h6c07_8965;
    localparam logic [WORD_W-1:0] TWIST_MATRIX = 32'h9908_b0df;
    localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9d2c_5680;
    localparam logic [WORD_W-1:0] TEMPER_C     = 32'hefc6_0000;
    localparam logic [WORD_W-1:0] UPPER_MASK   = 32'h8000_0000;
    localparam logic [WORD_W-1:0] LOWER_MASK   = 32'h7fff_ffff;
    localparam logic [WORD_W-1:0] SEED_RESET   = 32'd5489;

    // Sequencer states, one-hot
    typedef enum logic [6:0] {
        S_SEED     = 7'b000_0001,
        S_FILL_MUL = 7'b000_0010,
        S_FILL_WR  = 7'b000_0100,
        S_IDLE     = 7'b000_1000,
        S_RD_NXT   = 7'b001_0000,
        S_TWIST    = 7'b010_0000,
        S_SPARE    = 7'b100_0000
    } seq_state_t;

    // Output tempering: shifts, masks and XORs only
    function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] v;
        v = w;
        v = v ^ (v >> 11);
        v = v ^ ((v << 7) & TEMPER_B);
        v = v ^ ((v << 15) & TEMPER_C);
        v = v ^ (v >> 18);
        return v;
    endfunction

endpackage

// File: rtl/mtg_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mtg_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 624
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/mersenne_twister_generator.sv
// MT19937 generator: one shared state RAM stepped by a small sequencer; reseed fill, lazy twist, tempering.
// After reset, and after every reseed transfer, the block fills its 624-word state from the seed
// register, each word by a multiply step and then an add-and-write step; s_ready stays low
// throughout the fill. For a draw transfer (s_reseed low) the state RAM has one read port with
// registered data, so the next word and the word 397 places ahead are read one after the other and
// the twisted word is written back as the tempered result is loaded into the output register. The
// twist is done one word per draw, which gives the same sequence as twisting the whole state at
// once. The word at the read index is held in a register, so only two RAM reads are needed per
// draw. Writing the seed register alone does not reseed; it takes effect at the next reseed.
module mersenne_twister_generator (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [mtg_pkg::WORD_W-1:0]  cfg_wr_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_reseed,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [mtg_pkg::WORD_W-1:0]  m_random_word
);

    import mtg_pkg::*;

    seq_state_t        state_reg, state_next;
    logic [WORD_W-1:0] seed_reg;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [WORD_W-1:0] cur_reg, cur_next;
    logic [WORD_W-1:0] prev_reg, prev_next;
    logic [WORD_W-1:0] prod_reg, prod_next;
    logic [WORD_W-1:0] nxt_reg, nxt_next;
    logic [WORD_W-1:0] out_reg, out_next;
    logic              m_valid_reg, m_valid_next;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [IDX_W-1:0]  ram_raddr;
    logic [WORD_W-1:0] ram_rdata;

    logic              in_xfer;
    logic [IDX_W-1:0]  idx_inc;
    logic [IDX_W:0]    far_sum;
    logic [IDX_W-1:0]  far_idx;
    logic [WORD_W-1:0] fill_word;
    logic [WORD_W-1:0] mix_y;
    logic [WORD_W-1:0] twisted;

    mtg_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STATE_WORDS)
    ) u_state_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_ready       = (state_reg == S_IDLE) && (!m_valid_reg || m_ready);
    assign in_xfer       = s_valid && s_ready;
    assign m_valid       = m_valid_reg;
    assign m_random_word = out_reg;

    // Index arithmetic with wrap
    assign idx_inc = (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;
    assign far_sum = {1'b0, idx_reg} + FAR_OFFSET;
    assign far_idx = (far_sum >= WRAP_WORDS) ? IDX_W'(far_sum - WRAP_WORDS) : far_sum[IDX_W-1:0];

    // Seed recurrence and twist datapath
    assign fill_word = prod_reg + {{(WORD_W-IDX_W){1'b0}}, idx_reg};
    assign mix_y     = (cur_reg & UPPER_MASK) | (nxt_reg & LOWER_MASK);
    assign twisted   = ram_rdata ^ (mix_y >> 1) ^ (mix_y[0] ? TWIST_MATRIX : '0);

    // Sequencer and RAM control
    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        cur_next     = cur_reg;
        prev_next    = prev_reg;
        prod_next    = prod_reg;
        nxt_next     = nxt_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg;
        ram_we       = 1'b0;
        ram_waddr    = idx_reg;
        ram_wdata    = fill_word;
        ram_raddr    = idx_inc;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_SEED: begin
                ram_we     = 1'b1;
                ram_waddr  = '0;
                ram_wdata  = seed_reg;
                prev_next  = seed_reg;
                cur_next   = seed_reg;
                idx_next   = IDX_W'(1);
                state_next = S_FILL_MUL;
            end
            S_FILL_MUL: begin
                prod_next  = WORD_W'(SEED_MULT * (prev_reg ^ (prev_reg >> 30)));
                state_next = S_FILL_WR;
            end
            S_FILL_WR: begin
                ram_we    = 1'b1;
                prev_next = fill_word;
                if (idx_reg == LAST_IDX) begin
                    idx_next   = '0;
                    state_next = S_IDLE;
                end else begin
                    idx_next   = idx_inc;
                    state_next = S_FILL_MUL;
                end
            end
            S_IDLE: begin
                // next word read is issued on the draw transfer itself
                if (in_xfer) begin
                    state_next = s_reseed ? S_SEED : S_RD_NXT;
                end
            end
            S_RD_NXT: begin
                nxt_next   = ram_rdata;
                ram_raddr  = far_idx;
                state_next = S_TWIST;
            end
            S_TWIST: begin
                ram_we       = 1'b1;
                ram_wdata    = twisted;
                out_next     = temper(twisted);
                m_valid_next = 1'b1;
                cur_next     = nxt_reg;
                idx_next     = idx_inc;
                state_next   = S_IDLE;
            end
            default: begin
                state_next = S_SEED;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_SEED;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
            seed_reg    <= SEED_RESET;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                seed_reg <= cfg_wr_data;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        cur_reg  <= cur_next;
        prev_reg <= prev_next;
        prod_reg <= prod_next;
        nxt_reg  <= nxt_next;
        out_reg  <= out_next;
    end

    // Checks
    a_valid_from_twist: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_TWIST))
        else $error("result appeared without a twist step");

    a_twist_returns_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_TWIST) |=> (state_reg == S_IDLE) && m_valid_reg)
        else $error("twist step did not deliver a result");

    a_index_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (ram_waddr <= LAST_IDX) && (ram_raddr <= LAST_IDX))
        else $error("state RAM address out of range");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_TWIST) |-> !m_valid_reg || m_ready)
        else $error("pending result would be overwritten");

endmodule
